// File: rtl/kht_pkg.sv
// ----------------------------------------------------------------------------
// kht_pkg
// Shared types and constants of the key hold timer with auto-repeat.
// ----------------------------------------------------------------------------
package kht_pkg;

	// payload widths fixed by the item format
	localparam int unsigned MASK_W   = 16;
	localparam int unsigned QUERY_W  = 4;
	localparam int unsigned TIME_W   = 16;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_PRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD      = 2'd2;

	// register reset values
	localparam logic                  FIRST_PRESS_RST = 1'b1;
	localparam logic [CFG_DATA_W-1:0] DELAY_RST       = 16'd30;
	localparam logic [CFG_DATA_W-1:0] PERIOD_RST      = 16'd5;

	// controller to datapath commands
	typedef struct packed {
		logic latch_in;   // capture the accepted tick
		logic update;     // advance all key counters
		logic load_out;   // fill the result register
		logic rc_load;    // start a remainder for one key
		logic rc_write;   // store that remainder as the key's phase
		logic rc_active;  // phase rebuild owns the count read port
	} kht_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic rc_done;    // remainder ready
	} kht_status_t;

endpackage

// File: rtl/kht_in_if.sv
// ----------------------------------------------------------------------------
// kht_in_if
// Tick channel: sampled key levels and the key index to report.
// ----------------------------------------------------------------------------
interface kht_in_if
	import kht_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [MASK_W-1:0]  key_levels;
	logic [QUERY_W-1:0] query_key;

	modport source (output valid, output key_levels, output query_key, input ready);
	modport sink   (input valid, input key_levels, input query_key, output ready);
endinterface

// File: rtl/kht_out_if.sv
// ----------------------------------------------------------------------------
// kht_out_if
// Report channel: edge, level and repeat masks plus the queried hold time.
// ----------------------------------------------------------------------------
interface kht_out_if
	import kht_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] press_mask;
	logic [MASK_W-1:0] release_mask;
	logic [MASK_W-1:0] held_mask;
	logic [MASK_W-1:0] repeat_mask;
	logic [TIME_W-1:0] query_hold_time;

	modport source (output valid, output press_mask, output release_mask,
		output held_mask, output repeat_mask, output query_hold_time, input ready);
	modport sink   (input valid, input press_mask, input release_mask,
		input held_mask, input repeat_mask, input query_hold_time, output ready);
endinterface

// File: rtl/kht_rem.sv
// ----------------------------------------------------------------------------
// kht_rem
// Bit-serial restoring remainder: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module kht_rem
	import kht_pkg::*;
#(
	parameter int unsigned DW = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  logic [DW-1:0]         dividend,
	input  logic [CFG_DATA_W-1:0] divisor,
	output logic                  done,
	output logic [CFG_DATA_W-1:0] rem
);

	localparam int unsigned CNW = $clog2(DW + 1);

	logic [DW-1:0]         dvd_q;
	logic [CFG_DATA_W-1:0] rem_q;
	logic [CFG_DATA_W-1:0] div_q;
	logic [CNW-1:0]        step_q;
	logic                  busy_q;
	logic                  done_q;
	logic [CFG_DATA_W:0]   trial;
	logic [CFG_DATA_W-1:0] rem_nx;

	// shift in the next dividend bit and subtract if it fits
	always_comb begin
		trial = {rem_q, dvd_q[DW-1]};
		if (trial >= {1'b0, div_q}) begin
			rem_nx = CFG_DATA_W'(trial - {1'b0, div_q});
		end else begin
			rem_nx = trial[CFG_DATA_W-1:0];
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				busy_q <= 1'b1;
				step_q <= CNW'(DW);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == CNW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand registers
	always_ff @(posedge clk) begin
		if (load) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			rem_q <= rem_nx;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// File: rtl/kht_dpath.sv
// ----------------------------------------------------------------------------
// kht_dpath
// Key datapath: level history, hold counters, repeat phases, config
// registers and the result register.
// ----------------------------------------------------------------------------
module kht_dpath
	import kht_pkg::*;
#(
	parameter int unsigned NUM_KEYS    = 16,
	parameter int unsigned COUNT_WIDTH = 16,
	parameter int unsigned KIW         = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  kht_cmd_t              cmd,
	output kht_status_t           status,
	input  logic [KIW-1:0]        rc_idx,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [MASK_W-1:0]     key_levels,
	input  logic [QUERY_W-1:0]    query_key,
	output logic [MASK_W-1:0]     press_mask,
	output logic [MASK_W-1:0]     release_mask,
	output logic [MASK_W-1:0]     held_mask,
	output logic [MASK_W-1:0]     repeat_mask,
	output logic [TIME_W-1:0]     query_hold_time
);

	localparam int unsigned MW   = (NUM_KEYS > MASK_W) ? NUM_KEYS : MASK_W;
	localparam int unsigned CMPW = (COUNT_WIDTH > TIME_W) ? COUNT_WIDTH : TIME_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	logic                  first_q;
	logic [CFG_DATA_W-1:0] delay_q;
	logic [CFG_DATA_W-1:0] period_q;

	logic [NUM_KEYS-1:0]    lvl_q;
	logic [QUERY_W-1:0]     qry_q;
	logic [NUM_KEYS-1:0]    last_q;
	logic [COUNT_WIDTH-1:0] cnt_q [NUM_KEYS];
	logic [CFG_DATA_W-1:0]  ph_q  [NUM_KEYS];
	logic [NUM_KEYS-1:0]    press_q;
	logic [NUM_KEYS-1:0]    rel_q;
	logic [NUM_KEYS-1:0]    rep_q;

	logic [COUNT_WIDTH-1:0] cnt_nx [NUM_KEYS];
	logic [CFG_DATA_W-1:0]  ph_nx  [NUM_KEYS];
	logic [NUM_KEYS-1:0]    fire;

	logic [MW-1:0]          lvl_ext;
	logic [KIW-1:0]         q_idx;
	logic                   q_in_range;
	logic [KIW-1:0]         sel_idx;
	logic [COUNT_WIDTH-1:0] sel_cnt;
	logic [CMPW-1:0]        sel_ext;
	logic [TIME_W-1:0]      q_time;
	logic                   rc_done;
	logic [CFG_DATA_W-1:0]  rc_rem;

	logic [MASK_W-1:0] press_o_q;
	logic [MASK_W-1:0] rel_o_q;
	logic [MASK_W-1:0] held_o_q;
	logic [MASK_W-1:0] rep_o_q;
	logic [TIME_W-1:0] time_o_q;

	// configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= FIRST_PRESS_RST;
			delay_q  <= DELAY_RST;
			period_q <= PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FIRST_PRESS: first_q  <= cfg_data[0];
				REG_DELAY:       delay_q  <= cfg_data;
				REG_PERIOD:      period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input capture, upper keys read as up
	assign lvl_ext = MW'(key_levels);

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			lvl_q <= lvl_ext[NUM_KEYS-1:0];
			qry_q <= query_key;
		end
	end

	// per-key counter step and repeat decision
	always_comb begin
		for (int k = 0; k < NUM_KEYS; k++) begin
			cnt_nx[k] = cnt_q[k];
			ph_nx[k]  = ph_q[k];
			if (lvl_q[k] != last_q[k]) begin
				cnt_nx[k] = '0;
				ph_nx[k]  = '0;
			end else if (lvl_q[k] && (cnt_q[k] != CNT_MAX)) begin
				cnt_nx[k] = cnt_q[k] + 1'b1;
				ph_nx[k]  = ((ph_q[k] + 16'd1) == period_q) ? '0 : (ph_q[k] + 16'd1);
			end
			if (CMPW'(cnt_nx[k]) >= CMPW'(delay_q)) begin
				fire[k] = lvl_q[k] && ((CMPW'(cnt_nx[k]) == CMPW'(delay_q)) ||
					((period_q != '0) && (ph_nx[k] == '0)));
			end else begin
				fire[k] = lvl_q[k] && (cnt_nx[k] == '0) && first_q;
			end
		end
	end

	// key state, hold counters and repeat phases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			for (int k = 0; k < NUM_KEYS; k++) begin
				cnt_q[k] <= '0;
				ph_q[k]  <= '0;
			end
		end else if (cmd.update) begin
			last_q <= lvl_q;
			for (int k = 0; k < NUM_KEYS; k++) begin
				cnt_q[k] <= cnt_nx[k];
				ph_q[k]  <= ph_nx[k];
			end
		end else if (cmd.rc_write) begin
			ph_q[rc_idx] <= rc_rem;
		end
	end

	// edge and repeat masks of this tick
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			press_q <= lvl_q & ~last_q;
			rel_q   <= last_q & ~lvl_q;
			rep_q   <= fire;
		end
	end

	// shared count read port: phase rebuild or query
	assign q_idx      = KIW'(qry_q);
	assign q_in_range = (32'(qry_q) < 32'(NUM_KEYS));
	assign sel_idx    = cmd.rc_active ? rc_idx : q_idx;
	assign sel_cnt    = cnt_q[sel_idx];
	assign sel_ext    = CMPW'(sel_cnt);

	always_comb begin
		if (!q_in_range) begin
			q_time = '0;
		end else if (sel_ext > CMPW'(16'hFFFF)) begin
			q_time = 16'hFFFF;
		end else begin
			q_time = sel_ext[TIME_W-1:0];
		end
	end

	// serial remainder for phase rebuild after a period change
	kht_rem #(
		.DW(COUNT_WIDTH)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (cmd.rc_load),
		.dividend (sel_cnt),
		.divisor  (period_q),
		.done     (rc_done),
		.rem      (rc_rem)
	);

	assign status.rc_done = rc_done;

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			press_o_q <= MASK_W'(MW'(press_q));
			rel_o_q   <= MASK_W'(MW'(rel_q));
			held_o_q  <= MASK_W'(MW'(lvl_q));
			rep_o_q   <= MASK_W'(MW'(rep_q));
			time_o_q  <= q_time;
		end
	end

	assign press_mask      = press_o_q;
	assign release_mask    = rel_o_q;
	assign held_mask       = held_o_q;
	assign repeat_mask     = rep_o_q;
	assign query_hold_time = time_o_q;

endmodule

// File: rtl/kht_ctrl.sv
// ----------------------------------------------------------------------------
// kht_ctrl
// Sequencer: tick update, result hand-off and phase rebuild sweep.
// ----------------------------------------------------------------------------
module kht_ctrl
	import kht_pkg::*;
#(
	parameter int unsigned NUM_KEYS = 16,
	parameter int unsigned KIW      = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	output kht_cmd_t             cmd,
	input  kht_status_t          status,
	output logic [KIW-1:0]       rc_idx
);

	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_UPDATE  = 5'b00010,
		S_QUERY   = 5'b00100,
		S_RC_LOAD = 5'b01000,
		S_RC_RUN  = 5'b10000
	} state_t;

	state_t         state_q;
	state_t         state_nx;
	logic           pend_q;
	logic           pend_set;
	logic           rc_finish;
	logic           out_valid_q;
	logic [KIW-1:0] idx_q;
	logic           accept;
	logic           out_free;

	assign pend_set = cfg_we && (cfg_index == REG_PERIOD);
	assign in_ready = (state_q == S_IDLE) && !pend_q;
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign rc_finish = (state_q == S_RC_RUN) && status.rc_done &&
		(idx_q == KIW'(NUM_KEYS - 1));

	// next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.latch_in = 1'b1;
					state_nx     = S_UPDATE;
				end else if (pend_q) begin
					state_nx = S_RC_LOAD;
				end
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_nx   = S_QUERY;
			end
			S_QUERY: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			S_RC_LOAD: begin
				cmd.rc_active = 1'b1;
				cmd.rc_load   = 1'b1;
				state_nx      = S_RC_RUN;
			end
			S_RC_RUN: begin
				cmd.rc_active = 1'b1;
				if (status.rc_done) begin
					cmd.rc_write = 1'b1;
					state_nx     = rc_finish ? S_IDLE : S_RC_LOAD;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// state, pending rebuild, key index and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pend_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (pend_set) begin
				pend_q <= 1'b1;
			end else if (rc_finish) begin
				pend_q <= 1'b0;
			end
			if (state_q == S_IDLE) begin
				idx_q <= '0;
			end else if ((state_q == S_RC_RUN) && status.rc_done && !rc_finish) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign rc_idx    = idx_q;

endmodule

// File: rtl/key_hold_timer_auto_repeat_core.sv
// ----------------------------------------------------------------------------
// key_hold_timer_auto_repeat_core
// Per-key hold timer with press/release edges and typematic auto-repeat.
// ----------------------------------------------------------------------------
// a tick is captured in IDLE, then UPDATE steps the key state and QUERY loads
//   the result register once the output is free; a new tick is taken only in
//   IDLE after that load, and a pending result may wait while the next tick enters
// a repeat_period write rebuilds every key's phase with the serial remainder
//   unit, one key after another; no tick is taken until the rebuild ends
// reset clears levels, counters and phases and loads register defaults
module key_hold_timer_auto_repeat_core
	import kht_pkg::*;
#(
	parameter int unsigned NUM_KEYS    = 16,
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	kht_in_if.sink                ticks,
	kht_out_if.source             reports,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned KIW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

	kht_cmd_t       cmd;
	kht_status_t    status;
	logic [KIW-1:0] rc_idx;

	// sequencer
	kht_ctrl #(
		.NUM_KEYS (NUM_KEYS),
		.KIW      (KIW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ticks.valid),
		.in_ready  (ticks.ready),
		.out_valid (reports.valid),
		.out_ready (reports.ready),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cmd       (cmd),
		.status    (status),
		.rc_idx    (rc_idx)
	);

	// key datapath
	kht_dpath #(
		.NUM_KEYS    (NUM_KEYS),
		.COUNT_WIDTH (COUNT_WIDTH),
		.KIW         (KIW)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.rc_idx          (rc_idx),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.key_levels      (ticks.key_levels),
		.query_key       (ticks.query_key),
		.press_mask      (reports.press_mask),
		.release_mask    (reports.release_mask),
		.held_mask       (reports.held_mask),
		.repeat_mask     (reports.repeat_mask),
		.query_hold_time (reports.query_hold_time)
	);

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for key_hold_timer_auto_repeat_core. Ticks of key levels
// go in over the tick channel and a local predictor follows the levels, hold
// counters and repeat registers to work out each report. A checker compares
// every report field by field with the oldest prediction. Directed ticks cover
// edges, zero delay, zero period and an ignored register index. Random phases
// then run under several register settings, and a long hold keeps two keys
// down through many periodic repeats.
// ----------------------------------------------------------------------------
module testbench;
	import kht_pkg::*;

	// registers beyond the list are ignored by the block
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int unsigned NUM_KEYS   = 16;
	localparam int unsigned STALL_MAX  = 3000;
	localparam int unsigned SETTLE_CYC = 8;

	typedef struct packed {
		logic [MASK_W-1:0] press;
		logic [MASK_W-1:0] rel;
		logic [MASK_W-1:0] held;
		logic [MASK_W-1:0] rpt;
		logic [TIME_W-1:0] hold_time;
	} key_report_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	kht_in_if  ticks_ch ();
	kht_out_if reports_ch ();

	key_hold_timer_auto_repeat_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.ticks     (ticks_ch),
		.reports   (reports_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor state: kept levels, hold counters and register copies
	logic [MASK_W-1:0] kept_levels;
	logic [TIME_W-1:0] hold_cnt [NUM_KEYS];
	logic              pr_first_fires;
	logic [15:0]       pr_delay;
	logic [15:0]       pr_period;

	key_report_t report_q [$];
	int unsigned error_count;
	int unsigned quiet_cycles = 0;
	bit          steady;

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// advance the key state by one tick and return the report it causes
	function automatic key_report_t predict_report(input logic [MASK_W-1:0] levels,
			input logic [QUERY_W-1:0] query);
		key_report_t r;
		logic [TIME_W-1:0] c;
		int k;
		r.press = levels & ~kept_levels;
		r.rel   = kept_levels & ~levels;
		r.held  = levels;
		r.rpt   = '0;
		for (k = 0; k < NUM_KEYS; k++) begin
			if (levels[k] != kept_levels[k])
				hold_cnt[k] = '0;
			else if (levels[k] && hold_cnt[k] != '1)
				hold_cnt[k] = hold_cnt[k] + 1'b1;
			c = hold_cnt[k];
			if (levels[k]) begin
				if (c >= pr_delay)
					r.rpt[k] = (c == pr_delay) || (pr_period != 0 && (c % pr_period) == 0);
				else
					r.rpt[k] = (c == 0) && pr_first_fires;
			end
		end
		kept_levels = levels;
		r.hold_time = hold_cnt[query];
		return r;
	endfunction

	// one tick transaction; valid is left high for the next call to decide
	task automatic send_tick(input logic [MASK_W-1:0] levels, input logic [QUERY_W-1:0] query);
		if (!steady && $urandom_range(0, 99) < 27) begin
			ticks_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		ticks_ch.valid      <= 1'b1;
		ticks_ch.key_levels <= levels;
		ticks_ch.query_key  <= query;
		do @(posedge clk); while (!ticks_ch.ready);
		report_q.push_back(predict_report(levels, query));
	endtask

	// stop sending and let every outstanding report arrive
	task automatic wait_reports_done();
		ticks_ch.valid <= 1'b0;
		do @(posedge clk); while (report_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FIRST_PRESS: pr_first_fires = data[0];
			REG_DELAY:       pr_delay = data;
			REG_PERIOD:      pr_period = data;
			default:         ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_regs(input logic first, input logic [15:0] delay, input logic [15:0] period);
		write_reg(REG_FIRST_PRESS, {15'($urandom_range(0, 32767)), first});
		write_reg(REG_DELAY, delay);
		write_reg(REG_PERIOD, period);
	endtask

	// ---------------- tests ----------------

	// edges and field extremes under the reset register values
	task automatic test_edges();
		send_tick(16'hFFFF, 4'd15);
		send_tick(16'hFFFF, 4'd0);
		send_tick(16'h0000, 4'd15);
		send_tick(16'hA5A5, 4'd3);
		send_tick(16'h5A5A, 4'd4);
		send_tick(16'h5A5A, 4'd9);
		send_tick(16'h0001, 4'd0);
	endtask

	// zero delay fires on the press tick even without first-press firing
	task automatic test_zero_delay();
		int i;
		wait_reports_done();
		set_regs(1'b0, 16'd0, 16'd3);
		for (i = 0; i < 7; i++)
			send_tick(16'h8001, (i % 2) ? 4'd15 : 4'd0);
		send_tick(16'h0000, 4'd0);
	endtask

	// zero period leaves only the press and delay ticks
	task automatic test_zero_period();
		int i;
		wait_reports_done();
		set_regs(1'b1, 16'd2, 16'd0);
		for (i = 0; i < 5; i++)
			send_tick(16'h0100, 4'd8);
		send_tick(16'h0000, 4'd8);
	endtask

	// a write to an index beyond the list must change nothing
	task automatic test_ignored_index();
		wait_reports_done();
		write_reg(REG_UNUSED, 16'hFFFF);
		send_tick(16'h0003, 4'd1);
		send_tick(16'h0003, 4'd1);
	endtask

	// random key activity under several settings; levels carry over phases
	task automatic test_random_phases();
		int p, i, k, flip_pct;
		logic [MASK_W-1:0] levels, flips;
		levels = kept_levels;
		for (p = 0; p < 8; p++) begin
			wait_reports_done();
			case (p)
				0: set_regs(1'b1, 16'd0, 16'd1);
				1: set_regs(1'b0, 16'hFFFF, 16'hFFFF);
				2: set_regs(1'b1, 16'd3, 16'd2);
				3: set_regs(1'b0, 16'd1, 16'hFFFF);
				default: set_regs(1'($urandom_range(0, 1)), 16'($urandom_range(0, 24)),
					16'($urandom_range(1, 9)));
			endcase
			flip_pct = $urandom_range(3, 20);
			for (i = 0; i < 70; i++) begin
				// occasionally hold off until the block has drained
				if ($urandom_range(0, 49) == 0)
					wait_reports_done();
				if ($urandom_range(0, 9) == 0) begin
					levels = MASK_W'($urandom);
				end else begin
					flips = '0;
					for (k = 0; k < NUM_KEYS; k++)
						flips[k] = ($urandom_range(0, 99) < flip_pct);
					levels = levels ^ flips;
				end
				send_tick(levels, 4'($urandom_range(0, 15)));
			end
		end
	endtask

	// two keys held through the delay and many periodic repeats, no idling
	task automatic test_long_hold();
		int i, k;
		logic [MASK_W-1:0] levels, flips;
		wait_reports_done();
		set_regs(1'b0, 16'd12, 16'd7);
		steady = 1'b1;
		levels = MASK_W'($urandom) & ~16'h1020;
		send_tick(levels, 4'd5);
		for (i = 0; i < 60; i++) begin
			flips = '0;
			for (k = 0; k < NUM_KEYS; k++)
				flips[k] = ($urandom_range(0, 99) < 10);
			levels = (levels ^ flips) | 16'h1020;
			send_tick(levels, ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) :
				(i[0] ? 4'd12 : 4'd5));
		end
		steady = 1'b0;
	endtask

	// ---------------- report checking ----------------

	task automatic check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			error_count++;
			// keep the log readable when something goes badly wrong
			if (error_count <= 100)
				$error("%s: expected %h, got %h", name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		key_report_t want;
		if (arst_n && reports_ch.valid && reports_ch.ready) begin
			if (report_q.size() == 0) begin
				error_count++;
				$error("report transaction with no prediction waiting");
			end else begin
				want = report_q.pop_front();
				check_field("press_mask", want.press, reports_ch.press_mask);
				check_field("release_mask", want.rel, reports_ch.release_mask);
				check_field("held_mask", want.held, reports_ch.held_mask);
				check_field("repeat_mask", want.rpt, reports_ch.repeat_mask);
				check_field("query_hold_time", want.hold_time, reports_ch.query_hold_time);
			end
		end
	end

	// report side back-pressure
	always @(posedge clk) begin
		reports_ch.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 27);
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((ticks_ch.valid && ticks_ch.ready) || (reports_ch.valid && reports_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_MAX) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ---------------- main sequence ----------------
	initial begin
		int k;
		arst_n              = 1'b0;
		steady              = 1'b0;
		error_count         = 0;
		cfg_we              <= 1'b0;
		cfg_index           <= REG_FIRST_PRESS;
		cfg_data            <= '0;
		ticks_ch.valid      <= 1'b0;
		ticks_ch.key_levels <= '0;
		ticks_ch.query_key  <= '0;
		kept_levels         = '0;
		for (k = 0; k < NUM_KEYS; k++)
			hold_cnt[k] = '0;
		pr_first_fires = FIRST_PRESS_RST;
		pr_delay       = DELAY_RST;
		pr_period      = PERIOD_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_edges();
		test_zero_delay();
		test_zero_period();
		test_ignored_index();
		test_random_phases();
		test_long_hold();

		wait_reports_done();
		repeat (SETTLE_CYC) @(posedge clk);
		if (report_q.size() != 0) begin
			error_count++;
			$error("%0d predicted reports never arrived", report_q.size());
		end
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
